@@ src/npcr_pkg.sv @@
// Shared types and codes for the nearest point coverage radius unit.
package npcr_pkg;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] coordinate;
   } req_type_type;

   typedef struct packed {
      logic [31:0] distance;
      logic [31:0] max_radius;
      logic        no_tower;
   } rsp_type_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture request, start search bounds
      logic rd_mid;     // read store at mid
      logic step;       // update search bounds with read data
      logic rd_below;   // read store at lo - 1
      logic take_hit;   // capture entry at lo as candidate
      logic finish;     // form result
      logic shift_rd;   // read entry at shift pointer - 1
      logic shift_wr;   // write it one place up, move pointer down
      logic put;        // write new tower at lo, bump count
      logic clear;      // empty store and maximum
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic search_done;
      logic found_equal;
      logic full;
      logic empty;
      logic lo_at_count;
      logic lo_zero;
      logic shift_done;
   } sts_type;

endpackage

@@ src/npcr_datapath.sv @@
// Datapath: tower store, search bounds, distance and running maximum.
module npcr_datapath import npcr_pkg::*; #(
   parameter int TOWERS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type_type req_data,
   input  cmd_type      cmd,
   output sts_type      sts,
   output rsp_type_type rsp_data
);
   localparam int AW = (TOWERS > 1) ? $clog2(TOWERS) : 1;
   localparam int CW = $clog2(TOWERS + 1);

   logic signed [31:0] store_mem [TOWERS];
   logic signed [31:0] rd_ff;
   logic signed [31:0] x_ff;
   logic [CW-1:0] count_ff, count_in, lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] dist_ff, dist_in;
   logic        have_ff, have_in;
   rsp_type_type rsp_ff, rsp_in;
   logic [CW-1:0] mid;
   logic [CW-1:0] rd_addr;
   logic          rd_en, wr_en;
   logic [CW-1:0] wr_addr;
   logic signed [31:0] wr_data;
   logic [32:0] diff;
   logic [31:0] absd;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      rd_addr = mid;
      if (cmd.rd_below) rd_addr = lo_ff - 1'b1;
      else if (cmd.shift_rd) rd_addr = ptr_ff - 1'b1;
      else if (cmd.take_hit) rd_addr = lo_ff;
   end
   assign rd_en = cmd.rd_mid | cmd.rd_below | cmd.shift_rd | cmd.take_hit;
   assign wr_en = cmd.shift_wr | cmd.put;
   assign wr_addr = cmd.put ? lo_ff : ptr_ff;
   assign wr_data = cmd.put ? x_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr[AW-1:0]] <= wr_data;
      if (rd_en) rd_ff <= store_mem[rd_addr[AW-1:0]];
   end

   assign diff = {rd_ff[31], rd_ff} - {x_ff[31], x_ff};
   assign absd = diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];

   always_comb begin
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      ptr_in   = ptr_ff;
      max_in   = max_ff;
      dist_in  = dist_ff;
      have_in  = have_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         lo_in   = '0;
         hi_in   = count_ff;
         ptr_in  = count_ff;
         dist_in = '1;
         have_in = 1'b0;
      end
      if (cmd.step) begin
         if (rd_ff < x_ff) lo_in = mid + 1'b1;
         else hi_in = mid;
      end
      // Candidate read from either neighbor lands in rd_ff in the next cycle.
      if (have_ff) begin
         if (absd < dist_ff) dist_in = absd;
         have_in = 1'b0;
      end
      if (cmd.take_hit | cmd.rd_below) have_in = 1'b1;
      if (cmd.shift_wr) ptr_in = ptr_ff - 1'b1;
      if (cmd.put) count_in = count_ff + 1'b1;
      if (cmd.finish) begin
         rsp_in.distance   = dist_ff;
         rsp_in.no_tower   = (count_ff == '0);
         rsp_in.max_radius = (dist_ff > max_ff) ? dist_ff : max_ff;
         max_in            = rsp_in.max_radius;
      end
      if (cmd.clear) begin
         count_in = '0;
         max_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= '0;
         have_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         have_ff  <= have_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      ptr_ff  <= ptr_in;
      dist_ff <= dist_in;
      rsp_ff  <= rsp_in;
      if (cmd.load) x_ff <= req_data.coordinate;
   end

   assign sts.search_done = (lo_ff == hi_ff);
   assign sts.found_equal = (rd_ff == x_ff);
   assign sts.full        = (count_ff == CW'(TOWERS));
   assign sts.empty       = (count_ff == '0);
   assign sts.lo_at_count = (lo_ff == count_ff);
   assign sts.lo_zero     = (lo_ff == '0);
   assign sts.shift_done  = (ptr_ff == lo_ff);
   assign rsp_data        = rsp_ff;

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= CW'(TOWERS);
   endproperty
   a_count_bound: assert property (p_count_bound) else $error("count over depth");

   property p_bounds;
      @(posedge clock) disable iff (reset) $past(cmd.step) |-> lo_ff <= hi_ff;
   endproperty
   a_bounds: assert property (p_bounds) else $error("search bounds crossed");

   property p_max_grows;
      @(posedge clock) disable iff (reset)
         $past(cmd.finish) && !$past(reset) |-> max_ff >= $past(max_ff);
   endproperty
   a_max_grows: assert property (p_max_grows) else $error("maximum shrank");

endmodule

@@ src/npcr_controller.sv @@
// Controller: sequences search, neighbor check, shifting insert and result.
module npcr_controller import npcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic [1:0] req_kind,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_stall
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SRCH   = 4'd1;
   localparam logic [3:0] S_STEP   = 4'd2;
   localparam logic [3:0] S_ICHK   = 4'd3;
   localparam logic [3:0] S_IHIT   = 4'd4;
   localparam logic [3:0] S_SHRD   = 4'd5;
   localparam logic [3:0] S_SHWR   = 4'd6;
   localparam logic [3:0] S_QHI    = 4'd7;
   localparam logic [3:0] S_QLO    = 4'd8;
   localparam logic [3:0] S_QW1    = 4'd9;
   localparam logic [3:0] S_QW2    = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;
   localparam logic [3:0] S_RESULT = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       is_query_ff, is_query_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // Stall requests while busy; a pending result is held only while it is stalled, and a new item may still start.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      is_query_in  = is_query_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == REQ_CLEAR) cmd.clear = 1'b1;
               else if (req_kind == REQ_INSERT || req_kind == REQ_QUERY) begin
                  cmd.load    = 1'b1;
                  is_query_in = (req_kind == REQ_QUERY);
                  state_in    = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (sts.search_done) state_in = is_query_ff ? S_QHI : S_ICHK;
            else begin
               cmd.rd_mid = 1'b1;
               state_in   = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_SRCH;
         end
         S_ICHK: begin
            if (sts.lo_at_count) state_in = sts.full ? S_IDLE : S_SHRD;
            else begin
               cmd.take_hit = 1'b1;
               state_in     = S_IHIT;
            end
         end
         S_IHIT: begin
            // take_hit armed the candidate logic; that is harmless for insert.
            if (sts.found_equal || sts.full) state_in = S_IDLE;
            else state_in = S_SHRD;
         end
         S_SHRD: begin
            if (sts.shift_done) begin
               cmd.put  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHRD;
         end
         S_QHI: begin
            if (!sts.lo_at_count) cmd.take_hit = 1'b1;
            state_in = S_QLO;
         end
         S_QLO: begin
            if (!sts.lo_zero) cmd.rd_below = 1'b1;
            state_in = S_QW1;
         end
         S_QW1: state_in = S_QW2;
         S_QW2: state_in = S_FIN;
         S_FIN: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.finish = 1'b1;
               state_in   = S_RESULT;
            end
         end
         S_RESULT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         is_query_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_query_ff  <= is_query_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   property p_one_cmd;
      @(posedge clock) disable iff (reset)
         $countones({cmd.load, cmd.step, cmd.finish, cmd.put, cmd.clear}) <= 1;
   endproperty
   a_one_cmd: assert property (p_one_cmd) else $error("conflicting commands");

   property p_rsp_after_fin;
      @(posedge clock) disable iff (reset) cmd.finish |=> state_ff == S_RESULT;
   endproperty
   a_rsp_after_fin: assert property (p_rsp_after_fin) else $error("result lost");

   property p_finish_free;
      @(posedge clock) disable iff (reset) cmd.finish |-> !(rsp_valid_ff && rsp_stall);
   endproperty
   a_finish_free: assert property (p_finish_free) else $error("result overwrite");

endmodule

@@ src/nearest_point_coverage_radius_unit.sv @@
// Top level of the nearest point coverage radius unit.
// Keeps a sorted, duplicate-free store of up to TOWERS tower coordinates.
// req channel: req_valid, req_stall, req_data {req_type, coordinate}.
//   Insert (0) adds a coordinate, query (1) yields one rsp transaction,
//   clear (2) empties the store and the maximum; code 3 is dropped.
// rsp channel: rsp_valid, rsp_stall, rsp_data {distance, max_radius, no_tower}.
// A query is a lower-bound binary search on the store's single read port,
// with at most floor(log2(count))+1 steps, each a read at mid and then a
// bound update; rsp_valid rises once the result is formed, and the
// controller is then idle and can take the next item.
// An insert searches the same way, then moves every larger entry up one place,
// one entry at a time with a read and then a write. Clear is done without
// leaving the idle state. One item is in work at a time.
// The result sits in an output register; while rsp_stall holds it, the next
// item may be accepted and worked on, and only its finish waits.
// Reset empties the store and clears the maximum; no clearing pass is needed.
module nearest_point_coverage_radius_unit import npcr_pkg::*; #(
   parameter int TOWERS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   // Sequence each transaction.
   npcr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_data.req_type),
      .sts       (sts),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   // Hold store, bounds and maximum.
   npcr_datapath #(.TOWERS(TOWERS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

@@ tb/nearest_point_coverage_radius_unit_tb.sv @@
// Testbench for the nearest point coverage radius unit: predictor, stimulus and checker.
module nearest_point_coverage_radius_unit_tb;
   import npcr_pkg::*;

   localparam int TOWERS      = 1024;
   localparam int CYCLE_LIMIT = 4000000;
   // The slowest item is an insert that shifts the whole store.
   localparam int DRAIN_WAIT  = 2 * TOWERS + 64;
   // Request code with no meaning; the block drops it.
   localparam logic [1:0] REQ_SPARE = 2'd3;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_type_type rsp_data;

   nearest_point_coverage_radius_unit #(.TOWERS(TOWERS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Shadow copy of the block state: ascending tower list and running maximum.
   logic signed [31:0] towers_sorted[$];
   logic [31:0]        radius_shadow;
   rsp_type_type       pending_answers[$];

   int  fail_count;
   int  cycle_count;
   int  sent_count;
   int  query_count;
   int  answer_count;
   bit  sender_idles;
   bit  receiver_idles;
   int  stall_hold;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Random stall on the result side while receiver_idles is set: mostly short, now and then a long hold.
   always @(posedge clock) begin
      if (!receiver_idles) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
         stall_hold <= $urandom_range(10, 60);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   // Compare each accepted result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_count <= answer_count + 1;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.distance !== want.distance) begin
               $display("%0t: distance expected %h actual %h",
                        $time, want.distance, rsp_data.distance);
               fail_count++;
            end
            if (rsp_data.max_radius !== want.max_radius) begin
               $display("%0t: max_radius expected %h actual %h",
                        $time, want.max_radius, rsp_data.max_radius);
               fail_count++;
            end
            if (rsp_data.no_tower !== want.no_tower) begin
               $display("%0t: no_tower expected %b actual %b",
                        $time, want.no_tower, rsp_data.no_tower);
               fail_count++;
            end
         end
      end
   end

   function automatic int lower_bound_index(logic signed [31:0] x);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = towers_sorted.size();
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (towers_sorted[mid] < x) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic logic [31:0] span(logic signed [31:0] a, logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d[31:0];
   endfunction

   // Advance the shadow state by one accepted transaction.
   task automatic predict_coverage(req_type_type item);
      int           pos;
      rsp_type_type answer;
      pos = lower_bound_index(item.coordinate);
      case (item.req_type)
         REQ_INSERT: begin
            if (!(pos < towers_sorted.size() && towers_sorted[pos] == item.coordinate) &&
                towers_sorted.size() < TOWERS)
               towers_sorted.insert(pos, item.coordinate);
         end
         REQ_CLEAR: begin
            towers_sorted.delete();
            radius_shadow = '0;
         end
         REQ_QUERY: begin
            answer.distance = '1;
            answer.no_tower = (towers_sorted.size() == 0);
            if (!answer.no_tower) begin
               if (pos < towers_sorted.size())
                  answer.distance = span(towers_sorted[pos], item.coordinate);
               if (pos > 0 && span(item.coordinate, towers_sorted[pos - 1]) < answer.distance)
                  answer.distance = span(item.coordinate, towers_sorted[pos - 1]);
            end
            if (answer.distance > radius_shadow) radius_shadow = answer.distance;
            answer.max_radius = radius_shadow;
            pending_answers.insert(pending_answers.size(), answer);
            query_count++;
         end
         default: ;  // unused code: drop
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      if (!sender_idles) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Send one transaction; hold it until accepted, then predict.
   task automatic send_item(logic [1:0] kind, logic signed [31:0] coord);
      int           gap;
      req_type_type item;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.req_type   = kind;
      item.coordinate = coord;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_coverage(item);
      sent_count++;
   endtask

   // Coordinate mix: near an existing tower, small range, extremes, full range.
   function automatic logic signed [31:0] pick_coordinate();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20 && towers_sorted.size() > 0)
         return towers_sorted[$urandom_range(0, towers_sorted.size() - 1)] +
                $signed($urandom_range(0, 4)) - 2;
      if (r < 50) return $signed($urandom_range(0, 2000)) - 1000;
      if (r < 58) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0001;
            default: return 32'sh7fff_fffe;
         endcase
      end
      return $signed($urandom());
   endfunction

   task automatic test_empty_and_extremes();
      send_item(REQ_QUERY, 32'sd0);            // empty store: saturated distance
      send_item(REQ_QUERY, 32'sh7fff_ffff);
      send_item(REQ_CLEAR, 32'sd0);
      send_item(REQ_INSERT, 32'sh8000_0000);
      send_item(REQ_QUERY, 32'sh7fff_ffff);    // widest possible distance
      send_item(REQ_INSERT, 32'sh7fff_ffff);
      send_item(REQ_QUERY, 32'sd0);
      send_item(REQ_QUERY, 32'sh8000_0000);
      send_item(REQ_QUERY, 32'sh7fff_ffff);
      send_item(REQ_CLEAR, 32'sd0);
      send_item(REQ_INSERT, 32'sd10);
      send_item(REQ_INSERT, 32'sd20);
      send_item(REQ_QUERY, 32'sd15);           // tie between neighbors
      send_item(REQ_QUERY, -32'sd5);           // below every tower
      send_item(REQ_QUERY, 32'sd100);          // above every tower
   endtask

   task automatic test_duplicates_and_unused();
      send_item(REQ_INSERT, 32'sd10);          // duplicate: store unchanged
      send_item(REQ_INSERT, 32'sd20);
      send_item(REQ_SPARE, 32'sd5);            // unused code: ignored
      send_item(REQ_SPARE, -32'sd1);
      send_item(REQ_QUERY, 32'sd12);
      send_item(REQ_CLEAR, -32'sd1);
   endtask

   // Fill in ascending order so inserts append without long shifts.
   task automatic test_full_store();
      for (int i = 0; i < TOWERS; i++)
         send_item(REQ_INSERT, 32'sd1000 * i - 32'sd500000);
      send_item(REQ_INSERT, 32'sd7);           // full: dropped
      send_item(REQ_INSERT, 32'sh7fff_ffff);   // full: dropped
      send_item(REQ_INSERT, -32'sd500000);     // duplicate while full
      send_item(REQ_QUERY, 32'sd7);
      send_item(REQ_QUERY, 32'sh7fff_ffff);
      send_item(REQ_QUERY, 32'sh8000_0000);
      send_item(REQ_QUERY, 32'sd1500);
      send_item(REQ_CLEAR, 32'sd0);
   endtask

   task automatic test_random_traffic(int items);
      int r;
      for (int i = 0; i < items; i++) begin
         // Every 200 items, pick anew whether sender and receiver idle.
         if (i % 200 == 0) begin
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
         end
         r = $urandom_range(0, 99);
         // Keep the store small so inserts stay short.
         if (towers_sorted.size() > 48 && r < 10) send_item(REQ_CLEAR, $signed($urandom()));
         else if (r < 42) send_item(REQ_INSERT, pick_coordinate());
         else if (r < 93) send_item(REQ_QUERY, pick_coordinate());
         else if (r < 96) send_item(REQ_CLEAR, $signed($urandom()));
         else send_item(REQ_SPARE, $signed($urandom()));
      end
   endtask

   initial begin
      int waited;
      fail_count     = 0;
      cycle_count    = 0;
      sent_count     = 0;
      query_count    = 0;
      answer_count   = 0;
      stall_hold     = 0;
      radius_shadow  = '0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_extremes();
      test_duplicates_and_unused();
      test_full_store();
      test_random_traffic(450);
      req_valid <= 1'b0;

      waited = 0;
      while (pending_answers.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d transactions (%0d queries), checked %0d results,",
               sent_count, query_count, answer_count);
      $display("including empty, full-store, duplicate and extreme-coordinate cases.");
      if (fail_count == 0 && pending_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_answers.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/npcr_pkg.sv
src/npcr_datapath.sv
src/npcr_controller.sv
src/nearest_point_coverage_radius_unit.sv
tb/nearest_point_coverage_radius_unit_tb.sv
